@@ design/jfhs_pkg.sv @@
// Shared types and constants for the JPEG frame header scanner.
// Payload structs, parse phase encoding and marker byte values.
// No dependencies.
package jfhs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic        header_ok;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

  typedef enum logic [8:0] {
    PH_SIG0   = 9'b000000001,
    PH_SIG1   = 9'b000000010,
    PH_HUNT   = 9'b000000100,
    PH_MARK   = 9'b000001000,
    PH_LENHI  = 9'b000010000,
    PH_LENLO  = 9'b000100000,
    PH_SKIP   = 9'b001000000,
    PH_SOFHDR = 9'b010000000,
    PH_COMP   = 9'b100000000
  } phase_t;

  // marker class held in the field index while a length is read
  localparam logic [2:0] CLS_SKIP  = 3'd0;
  localparam logic [2:0] CLS_SOF0  = 3'd1;
  localparam logic [2:0] CLS_OTHER = 3'd2;

  // SOF0 header byte positions
  localparam logic [2:0] HDR_PREC  = 3'd0;
  localparam logic [2:0] HDR_HGTHI = 3'd1;
  localparam logic [2:0] HDR_HGTLO = 3'd2;
  localparam logic [2:0] HDR_WIDHI = 3'd3;
  localparam logic [2:0] HDR_WIDLO = 3'd4;

  // component record byte positions
  localparam logic [2:0] CMP_ID    = 3'd0;
  localparam logic [2:0] CMP_SAMP  = 3'd1;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] MRK_SOI   = 8'hD8;
  localparam logic [7:0] MRK_EOI   = 8'hD9;
  localparam logic [7:0] MRK_SOS   = 8'hDA;
  localparam logic [7:0] MRK_SOF0  = 8'hC0;
  localparam logic [7:0] MRK_SOF15 = 8'hCF;
  localparam logic [7:0] MRK_DHT   = 8'hC4;
  localparam logic [7:0] MRK_JPG   = 8'hC8;
  localparam logic [7:0] MRK_DAC   = 8'hCC;
  localparam logic [7:0] MRK_RST0  = 8'hD0;
  localparam logic [7:0] MRK_RST7  = 8'hD7;
  localparam logic [7:0] MRK_TEM   = 8'h01;
  localparam logic [7:0] MRK_NUL   = 8'h00;

  localparam logic [7:0] SAMP_11   = 8'h11;
  localparam logic [7:0] SAMP_22   = 8'h22;
  localparam logic [7:0] SAMP_21   = 8'h21;

  localparam logic [7:0]  PRECISION   = 8'd8;
  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] LEN_SOF_MIN = 16'd11;
  localparam logic [15:0] LEN_SOF_1C  = 16'd11;
  localparam logic [15:0] LEN_SOF_3C  = 16'd17;
  localparam logic [7:0]  NCOMP_1     = 8'd1;
  localparam logic [7:0]  NCOMP_3     = 8'd3;
  localparam logic [7:0]  TABLE_MAX   = 8'd3;

endpackage

@@ design/jfhs_parser.sv @@
// Byte-wise parse state and next-state logic of the frame header scanner.
// Updates on every transfer and flags the verdict in the same cycle.
// Depends on jfhs_pkg.
module jfhs_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  jfhs_pkg::item_t   item,
  output logic              res_valid,
  output jfhs_pkg::result_t res
);

  jfhs_pkg::phase_t phase, phase_next;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] skip_rem, skip_rem_next;
  logic [2:0]  fidx, fidx_next;
  logic [1:0]  ctot, ctot_next;
  logic [1:0]  cidx, cidx_next;
  logic [15:0] hgt, hgt_next;
  logic [15:0] wid, wid_next;
  logic        decided;

  logic        give;
  logic        give_ok;
  logic [7:0]  b;
  logic [15:0] len;
  logic [7:0]  samp;
  logic        samp_bad;
  logic        len_match;
  logic        standalone;
  logic        non_baseline;
  logic [1:0]  cidx_inc;

  assign b          = item.data_byte;
  assign len        = {seg_len[15:8], b};
  assign samp       = skip_rem[7:0];
  assign cidx_inc   = cidx + 2'd1;
  assign standalone = (b == jfhs_pkg::MRK_NUL) || (b == jfhs_pkg::MRK_SOI) ||
                      (b == jfhs_pkg::MRK_TEM) ||
                      ((b >= jfhs_pkg::MRK_RST0) && (b <= jfhs_pkg::MRK_RST7));
  assign non_baseline = (b > jfhs_pkg::MRK_SOF0) && (b <= jfhs_pkg::MRK_SOF15) &&
                        (b != jfhs_pkg::MRK_DHT) && (b != jfhs_pkg::MRK_JPG) &&
                        (b != jfhs_pkg::MRK_DAC);
  assign len_match = ((b == jfhs_pkg::NCOMP_1) && (seg_len == jfhs_pkg::LEN_SOF_1C)) ||
                     ((b == jfhs_pkg::NCOMP_3) && (seg_len == jfhs_pkg::LEN_SOF_3C));
  assign samp_bad  = (cidx == 2'd0) ?
                     ((samp != jfhs_pkg::SAMP_11) && (samp != jfhs_pkg::SAMP_22) &&
                      (samp != jfhs_pkg::SAMP_21)) :
                     (samp != jfhs_pkg::SAMP_11);

  always_comb begin
    phase_next    = phase;
    seg_len_next  = seg_len;
    skip_rem_next = skip_rem;
    fidx_next     = fidx;
    ctot_next     = ctot;
    cidx_next     = cidx;
    hgt_next      = hgt;
    wid_next      = wid;
    give          = 1'b0;
    give_ok       = 1'b0;
    if (!decided) begin
      case (phase)
        jfhs_pkg::PH_SIG0: begin
          if (b != jfhs_pkg::BYTE_FF) give = 1'b1;
          else phase_next = jfhs_pkg::PH_SIG1;
        end
        jfhs_pkg::PH_SIG1: begin
          if (b != jfhs_pkg::MRK_SOI) give = 1'b1;
          else phase_next = jfhs_pkg::PH_HUNT;
        end
        jfhs_pkg::PH_HUNT: begin
          if (b == jfhs_pkg::BYTE_FF) phase_next = jfhs_pkg::PH_MARK;
        end
        jfhs_pkg::PH_MARK: begin
          if (b != jfhs_pkg::BYTE_FF) begin
            if (standalone) begin
              phase_next = jfhs_pkg::PH_HUNT;
            end else if ((b == jfhs_pkg::MRK_EOI) || (b == jfhs_pkg::MRK_SOS)) begin
              give = 1'b1;
            end else begin
              if (b == jfhs_pkg::MRK_SOF0) fidx_next = jfhs_pkg::CLS_SOF0;
              else if (non_baseline) fidx_next = jfhs_pkg::CLS_OTHER;
              else fidx_next = jfhs_pkg::CLS_SKIP;
              phase_next = jfhs_pkg::PH_LENHI;
            end
          end
        end
        jfhs_pkg::PH_LENHI: begin
          seg_len_next = {b, 8'h00};
          phase_next   = jfhs_pkg::PH_LENLO;
        end
        jfhs_pkg::PH_LENLO: begin
          seg_len_next = len;
          if ((len < jfhs_pkg::LEN_MIN) || (fidx == jfhs_pkg::CLS_OTHER)) begin
            give = 1'b1;
          end else if (fidx == jfhs_pkg::CLS_SOF0) begin
            if (len < jfhs_pkg::LEN_SOF_MIN) begin
              give = 1'b1;
            end else begin
              fidx_next  = jfhs_pkg::HDR_PREC;
              phase_next = jfhs_pkg::PH_SOFHDR;
            end
          end else begin
            skip_rem_next = len - jfhs_pkg::LEN_MIN;
            phase_next    = (len != jfhs_pkg::LEN_MIN) ? jfhs_pkg::PH_SKIP
                                                       : jfhs_pkg::PH_HUNT;
          end
        end
        jfhs_pkg::PH_SKIP: begin
          skip_rem_next = skip_rem - 16'd1;
          if (skip_rem == 16'd1) phase_next = jfhs_pkg::PH_HUNT;
        end
        jfhs_pkg::PH_SOFHDR: begin
          fidx_next = fidx + 3'd1;
          case (fidx)
            jfhs_pkg::HDR_PREC:  if (b != jfhs_pkg::PRECISION) seg_len_next = 16'd0;
            jfhs_pkg::HDR_HGTHI: hgt_next = {b, 8'h00};
            jfhs_pkg::HDR_HGTLO: hgt_next = {hgt[15:8], b};
            jfhs_pkg::HDR_WIDHI: wid_next = {b, 8'h00};
            jfhs_pkg::HDR_WIDLO: wid_next = {wid[15:8], b};
            default: begin
              if (!len_match || (wid == 16'd0) || (hgt == 16'd0)) begin
                give = 1'b1;
              end else begin
                ctot_next  = b[1:0];
                cidx_next  = 2'd0;
                fidx_next  = jfhs_pkg::CMP_ID;
                phase_next = jfhs_pkg::PH_COMP;
              end
            end
          endcase
        end
        jfhs_pkg::PH_COMP: begin
          if (fidx == jfhs_pkg::CMP_ID) begin
            fidx_next = jfhs_pkg::CMP_SAMP;
          end else if (fidx == jfhs_pkg::CMP_SAMP) begin
            skip_rem_next = {8'h00, b};
            fidx_next     = fidx + 3'd1;
          end else if ((b > jfhs_pkg::TABLE_MAX) || samp_bad) begin
            give = 1'b1;
          end else begin
            cidx_next = cidx_inc;
            fidx_next = jfhs_pkg::CMP_ID;
            if (cidx_inc == ctot) begin
              give    = 1'b1;
              give_ok = 1'b1;
            end
          end
        end
        default: phase_next = jfhs_pkg::PH_HUNT;
      endcase
    end
  end

  assign res_valid        = step && (give || (item.end_of_file && !decided));
  assign res.header_ok    = give_ok;
  assign res.image_width  = give_ok ? wid : 16'd0;
  assign res.image_height = give_ok ? hgt : 16'd0;

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_file)) begin
      phase    <= jfhs_pkg::PH_SIG0;
      seg_len  <= 16'd0;
      skip_rem <= 16'd0;
      fidx     <= 3'd0;
      ctot     <= 2'd0;
      cidx     <= 2'd0;
      hgt      <= 16'd0;
      wid      <= 16'd0;
      decided  <= 1'b0;
    end else if (step) begin
      phase    <= phase_next;
      seg_len  <= seg_len_next;
      skip_rem <= skip_rem_next;
      fidx     <= fidx_next;
      ctot     <= ctot_next;
      cidx     <= cidx_next;
      hgt      <= hgt_next;
      wid      <= wid_next;
      decided  <= decided | give;
    end
  end

endmodule

@@ design/jpeg_frame_header_scanner.sv @@
// JPEG baseline frame header scanner, one file byte per transfer.
// The verdict is registered and presented in the cycle after the deciding byte is taken.
// Throughput: one byte per cycle, held off only while a result waits on result_stall.
// One result per file; bytes after a verdict are dropped until end of file.
// Reset (rst, synchronous) returns the parser to the signature check and clears
// result_valid; end of file does the same for the parser.
module jpeg_frame_header_scanner (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  jfhs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output jfhs_pkg::result_t result
);

  logic              step;
  logic              res_valid;
  jfhs_pkg::result_t res;

  assign item_stall = result_valid && result_stall;
  assign step       = item_valid && !item_stall;

  jfhs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

endmodule
